FILE: sv/pimdc_pkg.sv
// Shared types and constants for the two-motor PI duty controller.
// No dependencies; imported by every module of the block.
package pimdc_pkg;

    localparam logic [1:0] LIMIT_NONE = 2'd0;
    localparam logic [1:0] LIMIT_MAX  = 2'd1;
    localparam logic [1:0] LIMIT_MIN  = 2'd2;

    localparam logic [2:0] REG_KP_ONE       = 3'd0;
    localparam logic [2:0] REG_KP_TWO       = 3'd1;
    localparam logic [2:0] REG_KI_GAIN      = 3'd2;
    localparam logic [2:0] REG_DT_STEP      = 3'd3;
    localparam logic [2:0] REG_MAX_DUTY     = 3'd4;
    localparam logic [2:0] REG_MIN_DUTY     = 3'd5;
    localparam logic [2:0] REG_SPEED_TARGET = 3'd6;

    localparam logic [11:0] KP_RESET = 12'd420;
    localparam logic [15:0] KI_RESET = 16'd66;
    localparam logic [15:0] DT_RESET = 16'd4719;

    typedef struct packed {
        logic [11:0] kp_one;
        logic [11:0] kp_two;
        logic [15:0] ki;
        logic [15:0] dt;
        logic [11:0] max_duty;
        logic [11:0] min_duty;
        logic [15:0] speed_target;
    } cfg_t;

    typedef struct packed {
        logic        motor;
        logic [15:0] actual;
        logic [15:0] target;
        logic [11:0] duty;
    } item_t;

    typedef struct packed {
        logic [11:0] new_duty;
        logic [1:0]  status;
        logic        updated;
    } result_t;

endpackage

FILE: sv/pi_motor_duty_controller_top.sv
// Top level of the two-motor PI duty controller: stream ports, APB register
// file, integral state and pipeline control. Depends on pimdc_pkg, pimdc_calc.
//
// Use: each transfer on the slave stream carries one motor sample (encoder
// count, target count, present duty; motor select in s_tuser). One result
// transfer follows on the master stream with the new duty in m_tdata and the
// limit status and integral-updated flag in m_tuser.
// An input transfer loads the input register; the item then passes through
// the correction datapath into the output register, which drives m_tvalid.
// Throughput is one item per cycle while the receiver accepts results; the
// integral written by one item is seen by the next item in the following
// cycle, set by the single pass from the input register through the PI
// datapath into the integral registers. When the receiver stalls, the output
// register holds its result and the input register holds one further item;
// s_tready drops only when both are full. Reset clears both pipeline slots,
// both integrals to zero and loads the register defaults. Registers are
// written over APB at byte address 4*index; pready is always high and reads
// return the register values.
module pi_motor_duty_controller_top #(
    parameter int DUTY_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // actual_count[15:0], target_count[31:16], current_duty[43:32]
    input  logic [0:0]  s_tuser,  // motor_select[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // new_duty[11:0]
    output logic [2:0]  m_tuser   // limit_status[1:0], integral_updated[2]
);
    import pimdc_pkg::*;

    localparam int DUTY_EFF = (DUTY_BITS < 12) ? DUTY_BITS : 12;
    localparam logic [11:0] DUTY_MASK = 12'((1 << DUTY_EFF) - 1);

    cfg_t               cfg_reg, cfg_next;
    logic               in_valid_reg, in_valid_next;
    item_t              in_item_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_result_reg;
    logic signed [31:0] integ_one_reg, integ_one_next;
    logic signed [31:0] integ_two_reg, integ_two_next;

    logic               cfg_write;
    logic               take;
    logic               advance;
    logic signed [31:0] integ_sel;
    logic signed [31:0] integ_upd;
    result_t            calc_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_KP_ONE:       cfg_next.kp_one       = pwdata[11:0];
                REG_KP_TWO:       cfg_next.kp_two       = pwdata[11:0];
                REG_KI_GAIN:      cfg_next.ki           = pwdata[15:0];
                REG_DT_STEP:      cfg_next.dt           = pwdata[15:0];
                REG_MAX_DUTY:     cfg_next.max_duty     = pwdata[11:0] & DUTY_MASK;
                REG_MIN_DUTY:     cfg_next.min_duty     = pwdata[11:0] & DUTY_MASK;
                REG_SPEED_TARGET: cfg_next.speed_target = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_KP_ONE:       prdata = {20'd0, cfg_reg.kp_one};
            REG_KP_TWO:       prdata = {20'd0, cfg_reg.kp_two};
            REG_KI_GAIN:      prdata = {16'd0, cfg_reg.ki};
            REG_DT_STEP:      prdata = {16'd0, cfg_reg.dt};
            REG_MAX_DUTY:     prdata = {20'd0, cfg_reg.max_duty};
            REG_MIN_DUTY:     prdata = {20'd0, cfg_reg.min_duty};
            REG_SPEED_TARGET: prdata = {16'd0, cfg_reg.speed_target};
            default:          prdata = 32'd0;
        endcase
    end

    // Pipeline control: the input slot moves on whenever the output slot
    // is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign integ_sel = in_item_reg.motor ? integ_two_reg : integ_one_reg;

    pimdc_calc u_calc (
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .integ      (integ_sel),
        .result     (calc_result),
        .integ_next (integ_upd)
    );

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        integ_one_next = integ_one_reg;
        integ_two_next = integ_two_reg;
        if (advance)
        begin
            if (in_item_reg.motor)
                integ_two_next = integ_upd;
            else
                integ_one_next = integ_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_one       <= KP_RESET;
            cfg_reg.kp_two       <= KP_RESET;
            cfg_reg.ki           <= KI_RESET;
            cfg_reg.dt           <= DT_RESET;
            cfg_reg.max_duty     <= 12'd0;
            cfg_reg.min_duty     <= 12'd0;
            cfg_reg.speed_target <= 16'd0;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            integ_one_reg        <= 32'sd0;
            integ_two_reg        <= 32'sd0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            integ_one_reg <= integ_one_next;
            integ_two_reg <= integ_two_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.motor  <= s_tuser[0];
            in_item_reg.actual <= s_tdata[15:0];
            in_item_reg.target <= s_tdata[31:16];
            in_item_reg.duty   <= s_tdata[43:32] & DUTY_MASK;
        end
        if (advance)
            out_result_reg <= calc_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_result_reg.new_duty};
    assign m_tuser  = {out_result_reg.updated, out_result_reg.status};

endmodule

FILE: sv/pimdc_calc.sv
// PI correction datapath: error, proportional and integral terms, rounding,
// duty clamp and conditional integral step. Depends on pimdc_pkg.
module pimdc_calc (
    input  pimdc_pkg::cfg_t    cfg,
    input  pimdc_pkg::item_t   item,
    input  logic signed [31:0] integ,
    output pimdc_pkg::result_t result,
    output logic signed [31:0] integ_next
);
    import pimdc_pkg::*;

    logic signed [16:0] err;
    logic [11:0]        kp;
    logic signed [29:0] p_prod;
    logic signed [48:0] i_prod;
    logic signed [49:0] acc;
    logic signed [49:0] acc_rnd;
    logic signed [33:0] corr_wide;
    logic signed [15:0] corr;
    logic signed [17:0] sum;
    logic signed [33:0] e_dt;
    logic signed [33:0] e_dt_rnd;
    logic signed [17:0] step;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat;
    logic               unclamped;

    assign err    = $signed({1'b0, item.target}) - $signed({1'b0, item.actual});
    assign kp     = item.motor ? cfg.kp_two : cfg.kp_one;
    assign p_prod = $signed({1'b0, kp}) * err;
    assign i_prod = $signed({1'b0, cfg.ki}) * integ;
    assign acc    = $signed({{14{p_prod[29]}}, p_prod, 6'b0}) + 50'(i_prod);

    // Half away from zero: add one half, less one LSB when negative, then floor.
    assign acc_rnd   = acc + $signed(50'd32767) + $signed({49'd0, ~acc[49]});
    assign corr_wide = acc_rnd[49:16];

    always_comb
    begin
        if (corr_wide > $signed(34'sd32767))
            corr = 16'sh7fff;
        else if (corr_wide < -$signed(34'sd32768))
            corr = 16'sh8000;
        else
            corr = corr_wide[15:0];
    end

    assign sum = $signed({6'b0, item.duty}) + 18'(corr);

    // Integral step truncated toward zero.
    assign e_dt      = err * $signed({1'b0, cfg.dt});
    assign e_dt_rnd  = e_dt + $signed({18'd0, {16{e_dt[33]}}});
    assign step      = e_dt_rnd[33:16];
    assign integ_sum = 33'(integ) + 33'(step);

    always_comb
    begin
        if (integ_sum > $signed({2'b00, {31{1'b1}}}))
            integ_sat = {1'b0, {31{1'b1}}};
        else if (integ_sum < $signed({2'b11, {31{1'b0}}}))
            integ_sat = {1'b1, {31{1'b0}}};
        else
            integ_sat = integ_sum[31:0];
    end

    always_comb
    begin
        unclamped = 1'b0;
        if (sum > $signed({6'b0, cfg.max_duty}))
        begin
            result.new_duty = cfg.max_duty;
            result.status   = LIMIT_MAX;
        end
        else if (sum < $signed({6'b0, cfg.min_duty}))
        begin
            result.new_duty = cfg.min_duty;
            result.status   = LIMIT_MIN;
        end
        else
        begin
            result.new_duty = sum[11:0];
            result.status   = LIMIT_NONE;
            unclamped       = 1'b1;
        end
        result.updated = unclamped && (item.target == cfg.speed_target);
        integ_next     = result.updated ? integ_sat : integ;
    end

endmodule

FILE: sv/pimdc_checker.sv
// Port-level checks for the PI duty controller, bound to the top level.
// Depends on pimdc_pkg and pi_motor_duty_controller_top.
module pimdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import pimdc_pkg::*;

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // An integral advance only comes with an unclamped duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == LIMIT_NONE)
        else $error("integral advanced on a clamped duty");

    // Input back-pressure only when a result is held by a stalled receiver.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // An input transfer into an empty, free pipeline shows a result once it has passed the input and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid && m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after input transfer");

endmodule

bind pi_motor_duty_controller_top pimdc_checker u_pimdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/testbench.sv
// Self-checking testbench for the two-motor PI duty controller.
// Holds its own model of the gains, clamps and integrals and checks every result transfer
// against it. Depends on pimdc_pkg and pi_motor_duty_controller_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pimdc_pkg::*;

    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 100;
    localparam int HOLD_CYCLES   = 80;
    localparam int WIND_SAMPLES  = 12;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // actual_count[15:0], target_count[31:16], current_duty[43:32]
    logic [0:0]  s_tuser = '0;   // motor_select[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // new_duty[11:0]
    logic [2:0]  m_tuser;        // limit_status[1:0], integral_updated[2]

    // model of the block
    cfg_t               setting;
    logic signed [31:0] integral_one;
    logic signed [31:0] integral_two;
    result_t            duty_expected[$];

    bit          quiet = 1'b0;
    logic        hold_off = 1'b0;
    bit          took = 1'b0;
    logic [11:0] got_duty;
    logic [1:0]  got_status;
    logic        got_updated;
    int          errors = 0;
    int          samples_sent = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int          cycle_count = 0;

    pi_motor_duty_controller_top #(.DUTY_BITS(12)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic int idle_draw();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    // One control step: duty correction, clamp, conditional integration.
    function automatic result_t advance_controller(item_t s);
        result_t r;
        longint  tgt_v, act_v, err, kp_v, ki_v, dt_v, i_v;
        longint  duty_v, max_v, min_v, acc, mag, corr, sum, stp, nxt;
        tgt_v  = s.target;
        act_v  = s.actual;
        err    = tgt_v - act_v;
        kp_v   = s.motor ? setting.kp_two : setting.kp_one;
        ki_v   = setting.ki;
        dt_v   = setting.dt;
        duty_v = s.duty;
        max_v  = setting.max_duty;
        min_v  = setting.min_duty;
        i_v    = s.motor ? integral_two : integral_one;
        r      = '0;

        // Q.16 correction, rounded half away from zero
        acc  = kp_v * err * 64 + ki_v * i_v;
        mag  = (acc < 0) ? -acc : acc;
        corr = (mag + 32768) >>> 16;
        if (acc < 0)
            corr = -corr;
        if (corr > 32767)
            corr = 32767;
        if (corr < -32768)
            corr = -32768;
        sum = duty_v + corr;

        if (sum > max_v)
        begin
            r.new_duty = setting.max_duty;
            r.status   = LIMIT_MAX;
        end
        else if (sum < min_v)
        begin
            r.new_duty = setting.min_duty;
            r.status   = LIMIT_MIN;
        end
        else
        begin
            r.new_duty = sum[11:0];
            r.status   = LIMIT_NONE;
            if (s.target == setting.speed_target)
            begin
                // step truncates toward zero, integral saturates at 32 bits
                stp = err * dt_v;
                mag = (stp < 0) ? -stp : stp;
                stp = (stp < 0) ? -(mag >>> 16) : (mag >>> 16);
                nxt = i_v + stp;
                if (nxt > 64'sd2147483647)
                    nxt = 64'sd2147483647;
                if (nxt < -64'sd2147483648)
                    nxt = -64'sd2147483648;
                if (s.motor)
                    integral_two = nxt[31:0];
                else
                    integral_one = nxt[31:0];
                r.updated = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] shadow_value(logic [2:0] idx);
        case (idx)
            REG_KP_ONE:       return {20'd0, setting.kp_one};
            REG_KP_TWO:       return {20'd0, setting.kp_two};
            REG_KI_GAIN:      return {16'd0, setting.ki};
            REG_DT_STEP:      return {16'd0, setting.dt};
            REG_MAX_DUTY:     return {20'd0, setting.max_duty};
            REG_MIN_DUTY:     return {20'd0, setting.min_duty};
            REG_SPEED_TARGET: return {16'd0, setting.speed_target};
            default:          return 32'd0;
        endcase
    endfunction

    function automatic item_t motor_sample(logic m, logic [15:0] act, logic [15:0] tgt,
                                           logic [11:0] duty);
        item_t s;
        s.motor  = m;
        s.actual = act;
        s.target = tgt;
        s.duty   = duty;
        return s;
    endfunction

    // Mostly samples at the running target with a small error, so that integration happens.
    function automatic item_t random_sample();
        item_t s;
        s.motor = 1'($urandom_range(0, 1));
        s.duty  = 12'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            7:
            begin
                s.target = 16'($urandom_range(0, 65535));
                s.actual = 16'($urandom_range(0, 65535));
            end
            8:
            begin
                s.target = setting.speed_target;
                s.actual = 16'($urandom_range(0, 65535));
            end
            9:
            begin
                s.target = 16'($urandom_range(0, 65535));
                s.actual = s.target + 16'($urandom_range(0, 64)) - 16'd32;
            end
            default:
            begin
                s.target = setting.speed_target;
                s.actual = s.target + 16'($urandom_range(0, 64)) - 16'd32;
            end
        endcase
        return s;
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(logic [2:0] idx, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        value = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(logic [2:0] idx);
        logic [31:0] value;
        apb_read(idx, value);
        if (value !== shadow_value(idx))
        begin
            errors++;
            $display("%0t: register %0d expected %0h got %0h", $time, idx, shadow_value(idx),
                     value);
        end
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] value);
        apb_write(idx, value);
        reg_writes++;
        case (idx)
            REG_KP_ONE:       setting.kp_one       = value[11:0];
            REG_KP_TWO:       setting.kp_two       = value[11:0];
            REG_KI_GAIN:      setting.ki           = value[15:0];
            REG_DT_STEP:      setting.dt           = value[15:0];
            REG_MAX_DUTY:     setting.max_duty     = value[11:0];
            REG_MIN_DUTY:     setting.min_duty     = value[11:0];
            REG_SPEED_TARGET: setting.speed_target = value[15:0];
            default:          ;
        endcase
        if (idx != REG_UNUSED)
            check_register(idx);
    endtask

    task automatic program_controller(logic [11:0] kp1, logic [11:0] kp2, logic [15:0] ki,
                                      logic [15:0] dt, logic [11:0] hi, logic [11:0] lo,
                                      logic [15:0] st);
        write_register(REG_KP_ONE, {20'd0, kp1});
        write_register(REG_KP_TWO, {20'd0, kp2});
        write_register(REG_KI_GAIN, {16'd0, ki});
        write_register(REG_DT_STEP, {16'd0, dt});
        write_register(REG_MAX_DUTY, {20'd0, hi});
        write_register(REG_MIN_DUTY, {20'd0, lo});
        write_register(REG_SPEED_TARGET, {16'd0, st});
    endtask

    task automatic send_sample(item_t s);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, s.duty, s.target, s.actual};
        s_tuser  <= s.motor;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        duty_expected.push_back(advance_controller(s));
        samples_sent++;
    endtask

    // Drop valid and hold until every result is back and the pipeline is empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (duty_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic hold_results(int n);
        hold_off <= 1'b1;
        repeat (n) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        took        = m_tvalid && m_tready;
        got_duty    = m_tdata[11:0];
        got_status  = m_tuser[1:0];
        got_updated = m_tuser[2];
    end

    initial
    begin : result_checker
        int      stall_left;
        result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (took)
            begin
                results_seen++;
                if (duty_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got duty %0d status %0d",
                             $time, got_duty, got_status);
                end
                else
                begin
                    want = duty_expected.pop_front();
                    if (got_duty !== want.new_duty)
                    begin
                        errors++;
                        $display("%0t: new_duty expected %0d got %0d", $time, want.new_duty,
                                 got_duty);
                    end
                    if (got_status !== want.status)
                    begin
                        errors++;
                        $display("%0t: limit_status expected %0d got %0d", $time, want.status,
                                 got_status);
                    end
                    if (got_updated !== want.updated)
                    begin
                        errors++;
                        $display("%0t: integral_updated expected %0b got %0b", $time,
                                 want.updated, got_updated);
                    end
                end
                stall_left = idle_draw();
            end
            m_tready <= (stall_left == 0) && !hold_off;
            if (stall_left > 0)
                stall_left--;
        end
    end

    // Reset values, then samples with both clamps at zero.
    task automatic test_reset_defaults();
        for (int i = 0; i < 7; i++)
            check_register(3'(i));
        send_sample(motor_sample(1'b0, 16'd0, 16'd0, 12'd0));
        send_sample(motor_sample(1'b1, 16'd0, 16'd0, 12'd4095));
        send_sample(motor_sample(1'b0, 16'd0, 16'd65535, 12'd0));
        send_sample(motor_sample(1'b1, 16'd65535, 16'd0, 12'd0));
        wait_drained();
    endtask

    // Oversized write data must be masked; a write past the last register must change nothing.
    task automatic test_register_file();
        for (int i = 0; i < 7; i++)
            write_register(3'(i), 32'hFFFF_FFFF);
        for (int i = 0; i < 7; i++)
            write_register(3'(i), $urandom());
        write_register(REG_UNUSED, $urandom());
        for (int i = 0; i < 7; i++)
            check_register(3'(i));
    endtask

    task automatic test_directed();
        program_controller(12'd512, 12'd4095, 16'd0, 16'd65535, 12'd4095, 12'd0, 16'd1000);
        // half a count either way rounds away from zero
        send_sample(motor_sample(1'b0, 16'd1000, 16'd1001, 12'd100));
        send_sample(motor_sample(1'b0, 16'd1000, 16'd999, 12'd100));
        send_sample(motor_sample(1'b1, 16'd0, 16'd1000, 12'd2000));
        // correction saturates in both directions
        send_sample(motor_sample(1'b1, 16'd0, 16'd65535, 12'd4095));
        send_sample(motor_sample(1'b1, 16'd65535, 16'd0, 12'd4095));
        send_sample(motor_sample(1'b0, 16'd990, 16'd1000, 12'd2048));
        send_sample(motor_sample(1'b0, 16'd1010, 16'd1000, 12'd0));
        send_sample(motor_sample(1'b1, 16'd1000, 16'd1000, 12'd4095));
        wait_drained();

        write_register(REG_KI_GAIN, 32'd65535);
        send_sample(motor_sample(1'b0, 16'd1000, 16'd1000, 12'd1000));
        send_sample(motor_sample(1'b1, 16'd1000, 16'd1000, 12'd0));
        wait_drained();

        // min above max: the max test wins, everything else lands on min
        write_register(REG_MAX_DUTY, 32'd100);
        write_register(REG_MIN_DUTY, 32'd3000);
        send_sample(motor_sample(1'b0, 16'd1000, 16'd1000, 12'd50));
        send_sample(motor_sample(1'b1, 16'd1000, 16'd1000, 12'd4000));
        send_sample(motor_sample(1'b0, 16'd500, 16'd400, 12'd100));
        send_sample(motor_sample(1'b1, 16'd400, 16'd500, 12'd3000));
        wait_drained();
    endtask

    task automatic program_phase(int ph);
        logic [11:0] lo, hi, tmp;
        lo = 12'($urandom_range(0, 1500));
        hi = 12'($urandom_range(2500, 4095));
        if ($urandom_range(0, 5) == 0)
        begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        case (ph)
            0: program_controller(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 12'h000,
                                  16'($urandom_range(0, 65535)));
            1: program_controller(12'h000, 12'h000, 16'h0000, 16'h0000, 12'h000, 12'hFFF,
                                  16'($urandom_range(0, 65535)));
            2: program_controller(12'h000, 12'h000, 16'h0000, 16'h0000, 12'hFFF, 12'h000,
                                  16'hFFFF);
            default: program_controller(12'($urandom_range(0, 1023)),
                                        12'($urandom_range(0, 1023)),
                                        16'($urandom_range(0, 4000)),
                                        16'($urandom_range(0, 65535)), hi, lo,
                                        16'($urandom_range(0, 65535)));
        endcase
    endtask

    task automatic test_random();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            program_phase(ph);
            quiet = (ph == 3) || ($urandom_range(0, 3) == 0);
            repeat (PHASE_SAMPLES) send_sample(random_sample());
        end
        quiet = 1'b0;
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering; input must stall once both slots fill.
    task automatic test_backpressure();
        quiet = 1'b1;
        fork
            hold_results(HOLD_CYCLES);
        join_none
        repeat (24) send_sample(random_sample());
        quiet = 1'b0;
        wait_drained();
    endtask

    // Wind motor one far positive and motor two far negative with full steps, then let
    // the integral term alone drive the correction into saturation.
    task automatic test_integral_saturation();
        quiet = 1'b1;
        program_controller(12'd0, 12'd0, 16'd0, 16'd65535, 12'd4095, 12'd0, 16'd65535);
        repeat (WIND_SAMPLES) send_sample(motor_sample(1'b0, 16'd0, 16'd65535, 12'd2048));
        wait_drained();

        write_register(REG_KI_GAIN, 32'd65535);
        send_sample(motor_sample(1'b0, 16'd0, 16'd1, 12'd0));
        wait_drained();

        write_register(REG_KI_GAIN, 32'd0);
        write_register(REG_SPEED_TARGET, 32'd0);
        repeat (WIND_SAMPLES) send_sample(motor_sample(1'b1, 16'd65535, 16'd0, 12'd2048));
        wait_drained();

        write_register(REG_KI_GAIN, 32'd65535);
        send_sample(motor_sample(1'b1, 16'd0, 16'd1, 12'd4095));
        send_sample(motor_sample(1'b0, 16'd0, 16'd1, 12'd0));
        quiet = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        setting = '0;
        setting.kp_one = KP_RESET;
        setting.kp_two = KP_RESET;
        setting.ki     = KI_RESET;
        setting.dt     = DT_RESET;
        integral_one   = '0;
        integral_two   = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_file();
        test_directed();
        test_random();
        test_backpressure();
        test_integral_saturation();
        wait_drained();

        $display("summary: %0d samples sent, %0d results checked, %0d register writes",
                 samples_sent, results_seen, reg_writes);
        $display("summary: clamps, rounding, correction saturation, integral wind-up, stalls");
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: pi_motor_duty_controller_top.f
sv/pimdc_pkg.sv
sv/pimdc_calc.sv
sv/pi_motor_duty_controller_top.sv
sv/pimdc_checker.sv
dv/testbench.sv
